// ===== rtl/core/rti_pkg.sv =====
// ----------------------------------------------------------------------------
// rti_pkg
// Shared types and constants of the ray/triangle intersection core.
// ----------------------------------------------------------------------------
package rti_pkg;

  // field formats
  localparam int unsigned COORD_W = 24;   // signed coordinate width
  localparam int unsigned FRAC_W  = 8;    // coordinate fraction bits
  localparam int unsigned DTHR_W  = 62;   // determinant threshold width
  localparam int unsigned T_W     = 31;   // ray parameter width, Q15.16
  localparam int unsigned T_SHIFT = 16;   // fraction bits of the ray parameter

  // datapath widths
  localparam int unsigned DIFF_W = COORD_W + 1;         // edge and offset vectors
  localparam int unsigned COF_W  = 2 * DIFF_W + 1;      // 2x2 cofactors
  localparam int unsigned LO_W   = DIFF_W + 1;          // low slice of a cofactor
  localparam int unsigned HI_W   = COF_W - LO_W;        // high slice of a cofactor
  localparam int unsigned PL_W   = DIFF_W + LO_W + 1;   // low partial product
  localparam int unsigned PH_W   = DIFF_W + HI_W;       // high partial product
  localparam int unsigned ACC_W  = DIFF_W + COF_W + 2;  // determinant, numerators
  localparam int unsigned DIV_W  = ACC_W + T_W;         // divider remainder

  // configuration register indexes
  localparam logic [2:0] CFG_ORG_X   = 3'd0;
  localparam logic [2:0] CFG_ORG_Y   = 3'd1;
  localparam logic [2:0] CFG_ORG_Z   = 3'd2;
  localparam logic [2:0] CFG_DIR_X   = 3'd3;
  localparam logic [2:0] CFG_DIR_Y   = 3'd4;
  localparam logic [2:0] CFG_DIR_Z   = 3'd5;
  localparam logic [2:0] CFG_DET_THR = 3'd6;
  localparam logic [2:0] CFG_T_THR   = 3'd7;

  // reset values: about 0.001 with 3*FRAC_W fraction bits, and one in Q15.16
  localparam logic [DTHR_W-1:0] DET_THR_RST = DTHR_W'((2 ** (3 * FRAC_W)) / 1000);
  localparam logic [T_W-1:0]    T_THR_RST   = T_W'(65536);

  typedef struct packed {
    logic signed [COORD_W-1:0] vert0_x;
    logic signed [COORD_W-1:0] vert0_y;
    logic signed [COORD_W-1:0] vert0_z;
    logic signed [COORD_W-1:0] vert1_x;
    logic signed [COORD_W-1:0] vert1_y;
    logic signed [COORD_W-1:0] vert1_z;
    logic signed [COORD_W-1:0] vert2_x;
    logic signed [COORD_W-1:0] vert2_y;
    logic signed [COORD_W-1:0] vert2_z;
  } tri_req_t;

  typedef struct packed {
    logic           hit;
    logic [T_W-1:0] hit_distance;
  } tri_res_t;

  // control that travels with each division
  typedef struct packed {
    logic valid;
    logic cand;   // triangle passed determinant, barycentric and sign tests
  } div_ctl_t;

endpackage

// ===== rtl/core/rti_div_pipe.sv =====
// ----------------------------------------------------------------------------
// rti_div_pipe
// Pipelined restoring divider, one quotient bit per stage, saturating at the
// largest ray parameter.
// ----------------------------------------------------------------------------
module rti_div_pipe (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  rti_pkg::div_ctl_t        ctl_i,
  input  logic [rti_pkg::DIV_W-1:0] num_i,
  input  logic [rti_pkg::DIV_W-1:0] den_i,
  output rti_pkg::div_ctl_t        ctl_o,
  output logic [rti_pkg::T_W-1:0]  quot_o
);
  import rti_pkg::*;

  localparam int unsigned NSTG = T_W + 1;

  div_ctl_t         ctl_q  [NSTG];
  logic             sat_q  [NSTG];
  logic [DIV_W-1:0] rem_q  [NSTG];
  logic [DIV_W-1:0] den_q  [NSTG];
  logic [T_W-1:0]   quot_q [NSTG];

  logic [DIV_W-1:0] rem_d  [NSTG];
  logic [T_W-1:0]   quot_d [NSTG];
  logic [DIV_W-1:0] shd;

  // stage j settles quotient bit T_W-j
  always_comb begin
    rem_d[0]  = num_i;
    quot_d[0] = '0;
    for (int j = 1; j < NSTG; j++) begin
      shd = den_q[j-1] << (T_W - j);
      if (rem_q[j-1] >= shd) begin
        rem_d[j]  = rem_q[j-1] - shd;
        quot_d[j] = quot_q[j-1] | (T_W'(1) << (T_W - j));
      end else begin
        rem_d[j]  = rem_q[j-1];
        quot_d[j] = quot_q[j-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < NSTG; j++) ctl_q[j] <= '0;
    end else begin
      ctl_q[0] <= ctl_i;
      for (int j = 1; j < NSTG; j++) ctl_q[j] <= ctl_q[j-1];
    end
  end

  always_ff @(posedge clk_i) begin
    den_q[0] <= den_i;
    sat_q[0] <= (num_i >= (den_i << T_W));
    for (int j = 1; j < NSTG; j++) begin
      den_q[j] <= den_q[j-1];
      sat_q[j] <= sat_q[j-1];
    end
    for (int j = 0; j < NSTG; j++) begin
      rem_q[j]  <= rem_d[j];
      quot_q[j] <= quot_d[j];
    end
  end

  assign ctl_o  = ctl_q[NSTG-1];
  assign quot_o = sat_q[NSTG-1] ? '1 : quot_q[NSTG-1];

endmodule

// ===== rtl/core/ray_triangle_intersect_core.sv =====
// ----------------------------------------------------------------------------
// ray_triangle_intersect_core
// Front-face ray/triangle test by Cramer's rule against a configured ray.
// ----------------------------------------------------------------------------
// One triangle request is taken in every clock cycle (busy_o stays low) and
// its result leaves on result_o, marked by a one-cycle result_valid_o;
// results come in request order and cannot be held off. The pipeline is six
// arithmetic stages plus the 32-stage divider that forms the ray parameter
// and one output register. Ray and threshold registers must be written through
// the cfg port while no request is in flight, which the block does not enforce.
module ray_triangle_intersect_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write port
  input  logic                         cfg_we_i,
  input  logic [2:0]                   cfg_idx_i,
  input  logic [rti_pkg::DTHR_W-1:0]   cfg_wdata_i,
  // triangle requests
  input  logic                         start_i,
  output logic                         busy_o,
  input  rti_pkg::tri_req_t            req_i,
  // results
  output logic                         result_valid_o,
  output rti_pkg::tri_res_t            result_o
);
  import rti_pkg::*;

  localparam int unsigned PIPE_DEPTH = 6 + (T_W + 1) + 1;

  // sign-extended difference of two coordinates
  function automatic logic signed [DIFF_W-1:0] sub_ext(
    input logic signed [COORD_W-1:0] x,
    input logic signed [COORD_W-1:0] y
  );
    sub_ext = DIFF_W'(x) - DIFF_W'(y);
  endfunction

  // 2x2 cofactor x1*y1 - x2*y2
  function automatic logic signed [COF_W-1:0] cof(
    input logic signed [DIFF_W-1:0] x1,
    input logic signed [DIFF_W-1:0] y1,
    input logic signed [DIFF_W-1:0] x2,
    input logic signed [DIFF_W-1:0] y2
  );
    logic signed [2*DIFF_W-1:0] p1;
    logic signed [2*DIFF_W-1:0] p2;
    p1  = x1 * y1;
    p2  = x2 * y2;
    cof = COF_W'(p1) - COF_W'(p2);
  endfunction

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic signed [COORD_W-1:0] org_q [3];
  logic signed [COORD_W-1:0] dir_q [3];
  logic [DTHR_W-1:0]         det_thr_q;
  logic [T_W-1:0]            t_thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        org_q[k] <= '0;
        dir_q[k] <= '0;
      end
      det_thr_q <= DET_THR_RST;
      t_thr_q   <= T_THR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ORG_X:   org_q[0]  <= cfg_wdata_i[COORD_W-1:0];
        CFG_ORG_Y:   org_q[1]  <= cfg_wdata_i[COORD_W-1:0];
        CFG_ORG_Z:   org_q[2]  <= cfg_wdata_i[COORD_W-1:0];
        CFG_DIR_X:   dir_q[0]  <= cfg_wdata_i[COORD_W-1:0];
        CFG_DIR_Y:   dir_q[1]  <= cfg_wdata_i[COORD_W-1:0];
        CFG_DIR_Z:   dir_q[2]  <= cfg_wdata_i[COORD_W-1:0];
        CFG_DET_THR: det_thr_q <= cfg_wdata_i;
        CFG_T_THR:   t_thr_q   <= cfg_wdata_i[T_W-1:0];
        default: ;
      endcase
    end
  end

  // the pipeline never stalls
  assign busy_o = 1'b0;

  // pipeline valid bits, stages one to five
  logic [4:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], start_i & ~busy_o};
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: matrix columns [-dir, v1-v0, v2-v0] and origin offset
  // ---------------------------------------------------------------------------
  logic signed [DIFF_W-1:0] a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q, i_q;
  logic signed [DIFF_W-1:0] w_q [3];

  always_ff @(posedge clk_i) begin
    a_q    <= sub_ext('0, dir_q[0]);
    d_q    <= sub_ext('0, dir_q[1]);
    g_q    <= sub_ext('0, dir_q[2]);
    b_q    <= sub_ext(req_i.vert1_x, req_i.vert0_x);
    e_q    <= sub_ext(req_i.vert1_y, req_i.vert0_y);
    h_q    <= sub_ext(req_i.vert1_z, req_i.vert0_z);
    c_q    <= sub_ext(req_i.vert2_x, req_i.vert0_x);
    f_q    <= sub_ext(req_i.vert2_y, req_i.vert0_y);
    i_q    <= sub_ext(req_i.vert2_z, req_i.vert0_z);
    w_q[0] <= sub_ext(org_q[0], req_i.vert0_x);
    w_q[1] <= sub_ext(org_q[1], req_i.vert0_y);
    w_q[2] <= sub_ext(org_q[2], req_i.vert0_z);
  end

  // ---------------------------------------------------------------------------
  // stage 2: nine cofactors, operands of stage 3 carried along
  // ---------------------------------------------------------------------------
  logic signed [COF_W-1:0]  ca_q, cb_q, cc_q, cd_q, ce_q, cf_q, cg_q, ch_q, ci_q;
  logic signed [DIFF_W-1:0] a2_q, b2_q, c2_q;
  logic signed [DIFF_W-1:0] w2_q [3];

  always_ff @(posedge clk_i) begin
    ca_q <= cof(e_q, i_q, f_q, h_q);
    cb_q <= cof(f_q, g_q, d_q, i_q);
    cc_q <= cof(d_q, h_q, e_q, g_q);
    cd_q <= cof(c_q, h_q, b_q, i_q);
    ce_q <= cof(a_q, i_q, c_q, g_q);
    cf_q <= cof(b_q, g_q, a_q, h_q);
    cg_q <= cof(b_q, f_q, c_q, e_q);
    ch_q <= cof(c_q, d_q, a_q, f_q);
    ci_q <= cof(a_q, e_q, b_q, d_q);
    a2_q <= a_q;
    b2_q <= b_q;
    c2_q <= c_q;
    w2_q <= w_q;
  end

  // ---------------------------------------------------------------------------
  // stage 3: twelve cofactor products, each split in two partial products
  // product k: 0..2 determinant, 3..5 t numerator, 6..8 u, 9..11 v
  // ---------------------------------------------------------------------------
  logic signed [COF_W-1:0]  mx [12];
  logic signed [DIFF_W-1:0] my [12];
  logic signed [PL_W-1:0]   pl_d [12];
  logic signed [PH_W-1:0]   ph_d [12];
  logic signed [LO_W:0]     lo_s [12];
  logic signed [PL_W-1:0]   pl_q [12];
  logic signed [PH_W-1:0]   ph_q [12];

  always_comb begin
    mx[0]  = ca_q;  my[0]  = a2_q;
    mx[1]  = cb_q;  my[1]  = b2_q;
    mx[2]  = cc_q;  my[2]  = c2_q;
    mx[3]  = ca_q;  my[3]  = w2_q[0];
    mx[4]  = cd_q;  my[4]  = w2_q[1];
    mx[5]  = cg_q;  my[5]  = w2_q[2];
    mx[6]  = cb_q;  my[6]  = w2_q[0];
    mx[7]  = ce_q;  my[7]  = w2_q[1];
    mx[8]  = ch_q;  my[8]  = w2_q[2];
    mx[9]  = cc_q;  my[9]  = w2_q[0];
    mx[10] = cf_q;  my[10] = w2_q[1];
    mx[11] = ci_q;  my[11] = w2_q[2];
    for (int k = 0; k < 12; k++) begin
      // low slice is taken unsigned, high slice keeps the sign
      lo_s[k] = {1'b0, mx[k][LO_W-1:0]};
      pl_d[k] = my[k] * lo_s[k];
      ph_d[k] = my[k] * $signed(mx[k][COF_W-1:LO_W]);
    end
  end

  always_ff @(posedge clk_i) begin
    pl_q <= pl_d;
    ph_q <= ph_d;
  end

  // ---------------------------------------------------------------------------
  // stage 4: join the partial products
  // ---------------------------------------------------------------------------
  logic signed [ACC_W-1:0] prod_d [12];
  logic signed [ACC_W-1:0] prod_q [12];

  always_comb begin
    for (int k = 0; k < 12; k++) begin
      prod_d[k] = (ACC_W'(ph_q[k]) <<< LO_W) + ACC_W'(pl_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // ---------------------------------------------------------------------------
  // stage 5: determinant and the three Cramer numerators
  // ---------------------------------------------------------------------------
  logic signed [ACC_W-1:0] det_q, nt_q, nu_q, nv_q;

  always_ff @(posedge clk_i) begin
    det_q <= prod_q[0] + prod_q[1]  + prod_q[2];
    nt_q  <= prod_q[3] + prod_q[4]  + prod_q[5];
    nu_q  <= prod_q[6] + prod_q[7]  + prod_q[8];
    nv_q  <= prod_q[9] + prod_q[10] + prod_q[11];
  end

  // ---------------------------------------------------------------------------
  // stage 6: culling, barycentric range and sign of t
  // ---------------------------------------------------------------------------
  logic signed [ACC_W-1:0] thr_s;
  logic signed [ACC_W:0]   nuv_s;
  logic                    det_ok, in_tri, t_pos;
  div_ctl_t                div_ctl_q;
  logic [DIV_W-1:0]        num_q, den_q;

  always_comb begin
    thr_s  = ACC_W'(det_thr_q);
    nuv_s  = (ACC_W+1)'(nu_q) + (ACC_W+1)'(nv_q);
    det_ok = det_q > thr_s;
    in_tri = !nu_q[ACC_W-1] && (nu_q <= det_q) &&
             !nv_q[ACC_W-1] && (nv_q <= det_q) &&
             (nuv_s <= (ACC_W+1)'(det_q));
    t_pos  = !nt_q[ACC_W-1] && (nt_q != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_ctl_q <= '0;
    end else begin
      div_ctl_q.valid <= vld_q[4];
      div_ctl_q.cand  <= det_ok & in_tri & t_pos;
    end
  end

  // t numerator scaled to Q15.16; both operands are positive for a candidate
  always_ff @(posedge clk_i) begin
    num_q <= DIV_W'(nt_q) << T_SHIFT;
    den_q <= DIV_W'(det_q);
  end

  // ---------------------------------------------------------------------------
  // divider: t = floor(numerator / determinant), saturating
  // ---------------------------------------------------------------------------
  div_ctl_t       div_out_ctl;
  logic [T_W-1:0] t_quot;

  rti_div_pipe u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (div_ctl_q),
    .num_i  (num_q),
    .den_i  (den_q),
    .ctl_o  (div_out_ctl),
    .quot_o (t_quot)
  );

  // ---------------------------------------------------------------------------
  // output register: distance threshold and result strobe
  // ---------------------------------------------------------------------------
  logic     res_vld_q;
  tri_res_t res_q;
  logic     hit_d;

  assign hit_d = div_out_ctl.cand && (t_quot > t_thr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= div_out_ctl.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.hit          <= hit_d;
    res_q.hit_distance <= hit_d ? t_quot : '0;
  end

  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

`ifndef NO_ASSERTIONS
  // every result comes from a request taken a fixed pipeline depth earlier
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start_i && !busy_o, PIPE_DEPTH))
    else $error("result without matching request");

  // a hit lies beyond the distance threshold
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.hit) |-> (result_o.hit_distance > t_thr_q))
    else $error("hit at or below distance threshold");

  // a culled triangle is no hit and carries no distance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_out_ctl.valid && !div_out_ctl.cand) |=> (!result_o.hit &&
      (result_o.hit_distance == '0)))
    else $error("culled triangle reported as hit");
`endif

endmodule
